FILE: rtl/cvmm_pkg.sv
// package for the complex vector by real matrix multiplier: sizes, item types, helpers
package cvmm_pkg;

   // matrix size limits
   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 32;

   // derived widths
   localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LEN_W    = $clog2(MAX_COLUMNS + 1);
   localparam int ROWCNT_W = $clog2(MAX_ROWS + 1);

   // datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 40;
   localparam int OUT_W    = 24;
   localparam int RND_SHIFT = 14;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = CSR_IDX_W'(1);

   // register reset values
   localparam logic [6:0] VECTOR_LENGTH_RESET = 7'd64;
   localparam logic [5:0] ROW_COUNT_RESET     = 6'd32;

   // input item function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   // input item
   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic [4:0]                 coef_row;
      logic [5:0]                 coef_col;
      logic signed [COEF_W-1:0]   coef_value;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [OUT_W-1:0] result_re;
      logic signed [OUT_W-1:0] result_im;
      logic [4:0]              row_index;
      logic                    last;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                     rd_en;
      logic [COL_W-1:0]         rd_addr;
      logic                     mul_en;
      logic                     acc_en;
      logic                     acc_last;
      logic                     shift_en;
      logic [COL_W-1:0]         wr_addr;
      logic signed [COEF_W-1:0] wr_data;
   } ctrl_type;

   // round half up to units of 2^14 accumulator LSBs and saturate to the output range
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]             biased;
      logic signed [ACC_W-RND_SHIFT:0]   quot;
      logic signed [ACC_W-RND_SHIFT:0]   out_max;
      logic signed [ACC_W-RND_SHIFT:0]   out_min;
      logic signed [OUT_W-1:0]           res;
      biased  = {acc[ACC_W-1], acc} + (ACC_W + 1)'(1 << (RND_SHIFT - 1));
      quot    = biased[ACC_W:RND_SHIFT];
      out_max = (ACC_W - RND_SHIFT + 1)'((1 << (OUT_W - 1)) - 1);
      out_min = -(ACC_W - RND_SHIFT + 1)'(1 << (OUT_W - 1));
      if (quot > out_max) begin
         res = out_max[OUT_W-1:0];
      end else if (quot < out_min) begin
         res = out_min[OUT_W-1:0];
      end else begin
         res = quot[OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/cvmm_cell.sv
// one row cell: coefficient column memory, two multipliers, accumulators, output shift stage
module cvmm_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cvmm_pkg::ctrl_type                     ctrl,
   input  logic                                   wr_en,
   input  logic signed [cvmm_pkg::SAMPLE_W-1:0]   sample_re,
   input  logic signed [cvmm_pkg::SAMPLE_W-1:0]   sample_im,
   input  logic signed [cvmm_pkg::ACC_W-1:0]      shift_in_re,
   input  logic signed [cvmm_pkg::ACC_W-1:0]      shift_in_im,
   output logic signed [cvmm_pkg::ACC_W-1:0]      shift_out_re,
   output logic signed [cvmm_pkg::ACC_W-1:0]      shift_out_im
);

   // coefficients of this row, one entry per column
   logic signed [cvmm_pkg::COEF_W-1:0] coef_mem [0:cvmm_pkg::MAX_COLUMNS-1];
   logic signed [cvmm_pkg::COEF_W-1:0] coef_rd_ff;

   logic signed [cvmm_pkg::PROD_W-1:0] prod_re_ff;
   logic signed [cvmm_pkg::PROD_W-1:0] prod_im_ff;

   logic signed [cvmm_pkg::ACC_W-1:0]  acc_re_ff;
   logic signed [cvmm_pkg::ACC_W-1:0]  acc_im_ff;
   logic signed [cvmm_pkg::ACC_W-1:0]  acc_re_in;
   logic signed [cvmm_pkg::ACC_W-1:0]  acc_im_in;

   logic signed [cvmm_pkg::ACC_W-1:0]  shift_re_ff;
   logic signed [cvmm_pkg::ACC_W-1:0]  shift_im_ff;

   // coefficient memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         coef_rd_ff <= coef_mem[ctrl.rd_addr];
      end
   end

   // products of the element with this row's coefficient
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_re_ff <= cvmm_pkg::PROD_W'(sample_re) * cvmm_pkg::PROD_W'(coef_rd_ff);
         prod_im_ff <= cvmm_pkg::PROD_W'(sample_im) * cvmm_pkg::PROD_W'(coef_rd_ff);
      end
   end

   // wrapping accumulate
   assign acc_re_in = acc_re_ff + cvmm_pkg::ACC_W'(prod_re_ff);
   assign acc_im_in = acc_im_ff + cvmm_pkg::ACC_W'(prod_im_ff);

   // accumulators, cleared when the vector ends
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (ctrl.acc_en) begin
         if (ctrl.acc_last) begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end else begin
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
         end
      end
   end

   // output stage: load the finished sums, then pass toward row zero
   always_ff @(posedge clock) begin
      if (ctrl.acc_en && ctrl.acc_last) begin
         shift_re_ff <= acc_re_in;
         shift_im_ff <= acc_im_in;
      end else if (ctrl.shift_en) begin
         shift_re_ff <= shift_in_re;
         shift_im_ff <= shift_in_im;
      end
   end

   assign shift_out_re = shift_re_ff;
   assign shift_out_im = shift_im_ff;

endmodule

FILE: rtl/complex_vector_real_matrix_multiply.sv
// top level: complex vector times stored real matrix over a chain of row cells
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_item (cvmm_pkg::req_type)
//   rsp      out        rsp_valid/rsp_stall   rsp_item (cvmm_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// a coefficient write or a sample element is taken whenever req_stall is low, one item per cycle.
// after the final element of a vector is taken, req_stall stays high through the multiply
// and accumulate stages (the coefficient read shares the accepting edge) and while the cell
// chain shifts its sums, one emitted row at a time, to the output register; rsp_stall
// lengthens that drain.
// reset is synchronous: accumulators clear, registers take their defaults, the
// coefficient memories keep whatever they hold.
module complex_vector_real_matrix_multiply (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cvmm_pkg::req_type                    req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cvmm_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cvmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cvmm_pkg::CSR_DATA_W-1:0]      csr_data
);

   // configuration registers
   logic [6:0] vector_length_ff;
   logic [5:0] row_count_ff;

   logic [cvmm_pkg::LEN_W-1:0]    len_c;
   logic [cvmm_pkg::ROWCNT_W-1:0] rows_c;

   // input side control
   logic                        req_accept;
   logic                        sample_accept;
   logic                        coef_accept;
   logic                        is_end;
   logic [cvmm_pkg::COL_W-1:0]  col_ff;
   logic                        busy_ff;

   // pipeline
   logic                                 v1_ff;
   logic                                 end1_ff;
   logic                                 v2_ff;
   logic                                 end2_ff;
   logic signed [cvmm_pkg::SAMPLE_W-1:0] s_re_ff;
   logic signed [cvmm_pkg::SAMPLE_W-1:0] s_im_ff;

   // drain
   logic [cvmm_pkg::ROWCNT_W-1:0] drain_left_ff;
   logic [cvmm_pkg::ROW_W-1:0]    out_row_ff;
   logic                          shift_en;

   // output register
   logic              rsp_valid_ff;
   cvmm_pkg::rsp_type rsp_item_ff;

   cvmm_pkg::ctrl_type ctrl;
   logic [cvmm_pkg::MAX_ROWS-1:0] wr_en;

   logic signed [cvmm_pkg::ACC_W-1:0] chain_re [0:cvmm_pkg::MAX_ROWS];
   logic signed [cvmm_pkg::ACC_W-1:0] chain_im [0:cvmm_pkg::MAX_ROWS];

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= cvmm_pkg::VECTOR_LENGTH_RESET;
         row_count_ff     <= cvmm_pkg::ROW_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cvmm_pkg::CSR_VECTOR_LENGTH: vector_length_ff <= csr_data[6:0];
            cvmm_pkg::CSR_ROW_COUNT:     row_count_ff     <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // clamp registers to the supported ranges
   always_comb begin
      if (vector_length_ff == '0) begin
         len_c = cvmm_pkg::LEN_W'(1);
      end else if (int'(vector_length_ff) > cvmm_pkg::MAX_COLUMNS) begin
         len_c = cvmm_pkg::LEN_W'(cvmm_pkg::MAX_COLUMNS);
      end else begin
         len_c = cvmm_pkg::LEN_W'(vector_length_ff);
      end
      if (row_count_ff == '0) begin
         rows_c = cvmm_pkg::ROWCNT_W'(1);
      end else if (int'(row_count_ff) > cvmm_pkg::MAX_ROWS) begin
         rows_c = cvmm_pkg::ROWCNT_W'(cvmm_pkg::MAX_ROWS);
      end else begin
         rows_c = cvmm_pkg::ROWCNT_W'(row_count_ff);
      end
   end

   // item acceptance
   assign req_stall     = busy_ff;
   assign req_accept    = req_valid && !req_stall;
   assign sample_accept = req_accept && (req_item.func == cvmm_pkg::FUNC_SAMPLE);
   assign coef_accept   = req_accept && (req_item.func == cvmm_pkg::FUNC_COEF)
                          && (int'(req_item.coef_col) < cvmm_pkg::MAX_COLUMNS);
   assign is_end        = (int'(col_ff) + 1) >= int'(len_c);

   // per-row coefficient write enables
   always_comb begin
      for (int r = 0; r < cvmm_pkg::MAX_ROWS; r++) begin
         wr_en[r] = coef_accept && (int'(req_item.coef_row) == r);
      end
   end

   // column counter, busy flag, pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         busy_ff       <= 1'b0;
         v1_ff         <= 1'b0;
         end1_ff       <= 1'b0;
         v2_ff         <= 1'b0;
         end2_ff       <= 1'b0;
         drain_left_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         v1_ff   <= sample_accept;
         end1_ff <= sample_accept && is_end;
         v2_ff   <= v1_ff;
         end2_ff <= end1_ff;
         if (sample_accept) begin
            if (is_end) begin
               col_ff  <= '0;
               busy_ff <= 1'b1;
            end else begin
               col_ff <= col_ff + cvmm_pkg::COL_W'(1);
            end
         end
         if (end2_ff) begin
            drain_left_ff <= rows_c;
            out_row_ff    <= '0;
         end else if (shift_en) begin
            drain_left_ff <= drain_left_ff - cvmm_pkg::ROWCNT_W'(1);
            out_row_ff    <= out_row_ff + cvmm_pkg::ROW_W'(1);
            if (drain_left_ff == cvmm_pkg::ROWCNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // element held for the multiply stage
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         s_re_ff <= req_item.sample_re;
         s_im_ff <= req_item.sample_im;
      end
   end

   // drain moves one row whenever the output register can take it
   assign shift_en = (drain_left_ff != '0) && (!rsp_valid_ff || !rsp_stall);

   // control to the cells
   always_comb begin
      ctrl.rd_en    = sample_accept;
      ctrl.rd_addr  = col_ff;
      ctrl.mul_en   = v1_ff;
      ctrl.acc_en   = v2_ff;
      ctrl.acc_last = end2_ff;
      ctrl.shift_en = shift_en;
      ctrl.wr_addr  = cvmm_pkg::COL_W'(req_item.coef_col);
      ctrl.wr_data  = req_item.coef_value;
   end

   // row cells, sums shift toward row zero
   assign chain_re[cvmm_pkg::MAX_ROWS] = '0;
   assign chain_im[cvmm_pkg::MAX_ROWS] = '0;

   for (genvar r = 0; r < cvmm_pkg::MAX_ROWS; r++) begin : g_cell
      cvmm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .wr_en        (wr_en[r]),
         .sample_re    (s_re_ff),
         .sample_im    (s_im_ff),
         .shift_in_re  (chain_re[r+1]),
         .shift_in_im  (chain_im[r+1]),
         .shift_out_re (chain_re[r]),
         .shift_out_im (chain_im[r])
      );
   end

   // output register with rounding and saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (shift_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         rsp_item_ff.result_re <= cvmm_pkg::round_sat(chain_re[0]);
         rsp_item_ff.result_im <= cvmm_pkg::round_sat(chain_im[0]);
         rsp_item_ff.row_index <= 5'(out_row_ff);
         rsp_item_ff.last      <= (int'(out_row_ff) + 1) == int'(rows_c);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // the chain only shifts while a vector is being drained
   a_shift_busy: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> busy_ff)
      else $error("cell chain shifted outside a drain");

   // a finished vector never lands on a drain still in progress
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && end2_ff) |-> (drain_left_ff == '0))
      else $error("vector end overlaps running drain");

   // idle means nothing pending in the pipeline or the drain
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (drain_left_ff == '0 && !end1_ff && !end2_ff))
      else $error("vector end pending while input is open");

endmodule
